>>> hw/rtl/rc4_pkg.sv
`default_nettype none
package rc4_pkg;

    // Default and largest supported key length in bytes
    localparam int KEY_MAX_DEF = 256;
    localparam int SBOX_DEPTH  = 256;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_KEY_IN  = 4'd1,
        OP_DATA_IN = 4'd2,
        OP_KS_RDN  = 4'd3,
        OP_KS_RDJ  = 4'd4,
        OP_KS_WRN  = 4'd5,
        OP_KS_WRJ  = 4'd6,
        OP_D_RDJ   = 4'd7,
        OP_D_WRI   = 4'd8,
        OP_D_WRJ   = 4'd9,
        OP_D_RDK   = 4'd10,
        OP_D_OUT   = 4'd11
    } t_dp_op;

    // Controller to datapath
    typedef struct packed {
        t_dp_op op;
        logic   ks_start;   // key request carries the last key byte
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ks_done;      // current schedule step is the final one
        logic out_free;     // output register can take a result this cycle
    } t_dp_sts;

endpackage
`default_nettype wire

>>> hw/rtl/rc4_stream_cipher_top.sv
// Key byte request without last: stored, and ready stays high. Last key byte: stored,
// then the key schedule runs with ready low, each step two reads and two writes on the
// single S-box port. Data byte request: five dependent S-box accesses on the single port
// (the first one in the accept cycle), then the output load; the next request is taken
// only after the load, and a stalled output holds the controller in the load step.
// Synchronous active-low reset: S-box reads as identity through per-entry valid bits,
// indices and key count clear at once; no clearing pass.
`default_nettype none
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tuser,   // [0] mode
    input  wire logic       s_axis_tlast,   // key_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [7:0] out_byte
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .i_key_last (s_axis_tlast),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    rc4_dp #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_byte   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> hw/rtl/rc4_ctrl.sv
`default_nettype none
module rc4_ctrl
    import rc4_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_mode,
    input  wire logic    i_key_last,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_KS_RDN = 10'b00_0000_0010,
        S_KS_RDJ = 10'b00_0000_0100,
        S_KS_WRN = 10'b00_0000_1000,
        S_KS_WRJ = 10'b00_0001_0000,
        S_D_RDJ  = 10'b00_0010_0000,
        S_D_WRI  = 10'b00_0100_0000,
        S_D_WRJ  = 10'b00_1000_0000,
        S_D_RDK  = 10'b01_0000_0000,
        S_D_OUT  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command
    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NOP;
        o_cmd.ks_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode) begin
                        o_cmd.op = OP_DATA_IN;
                        n_state  = S_D_RDJ;
                    end else begin
                        o_cmd.op       = OP_KEY_IN;
                        o_cmd.ks_start = i_key_last;
                        if (i_key_last) begin
                            n_state = S_KS_RDN;
                        end
                    end
                end
            end
            S_KS_RDN: begin
                o_cmd.op = OP_KS_RDN;
                n_state  = S_KS_RDJ;
            end
            S_KS_RDJ: begin
                o_cmd.op = OP_KS_RDJ;
                n_state  = S_KS_WRN;
            end
            S_KS_WRN: begin
                o_cmd.op = OP_KS_WRN;
                n_state  = S_KS_WRJ;
            end
            S_KS_WRJ: begin
                o_cmd.op = OP_KS_WRJ;
                n_state  = i_sts.ks_done ? S_IDLE : S_KS_RDN;
            end
            S_D_RDJ: begin
                o_cmd.op = OP_D_RDJ;
                n_state  = S_D_WRI;
            end
            S_D_WRI: begin
                o_cmd.op = OP_D_WRI;
                n_state  = S_D_WRJ;
            end
            S_D_WRJ: begin
                o_cmd.op = OP_D_WRJ;
                n_state  = S_D_RDK;
            end
            S_D_RDK: begin
                o_cmd.op = OP_D_RDK;
                n_state  = S_D_OUT;
            end
            S_D_OUT: begin
                // wait here until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.op = OP_D_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Data request always starts the keystream sequence
    a_data_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode) |=> (r_state == S_D_RDJ))
        else $error("data request did not start keystream sequence");

    // A result is only loaded when the output side has room
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_D_OUT) |-> i_sts.out_free)
        else $error("result loaded into a full output register");

endmodule
`default_nettype wire

>>> hw/rtl/rc4_dp.sv
`default_nettype none
module rc4_dp
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_out_ready,
    output t_dp_sts         o_sts,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte
);

    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_CW = $clog2(KEY_MAX + 1);

    // S-box storage with per-entry valid bits; an invalid entry reads as its index
    logic [7:0]            r_sbox [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] r_valid;
    logic [7:0]            r_s_rd;
    logic [7:0]            r_s_ra;
    logic                  r_s_vld;

    // Key storage
    logic [7:0]            r_key_mem [KEY_MAX];
    logic [7:0]            r_k_rd;
    logic [KEY_CW-1:0]     r_key_cnt;
    logic [KEY_CW-1:0]     r_key_len;
    logic [KEY_AW-1:0]     r_kpos;

    // Indices and working registers
    logic [7:0]            r_i;
    logic [7:0]            r_j;
    logic [7:0]            r_tmp_a;
    logic [7:0]            r_tmp_b;
    logic [7:0]            r_byte;
    logic                  r_out_vld;
    logic [7:0]            r_out_data;

    logic [7:0]            s_val;
    logic                  s_re;
    logic [7:0]            s_ra;
    logic                  s_we;
    logic [7:0]            s_wa;
    logic [7:0]            s_wd;
    logic [7:0]            j_nxt;
    logic                  key_room;
    logic [KEY_CW-1:0]     key_cnt_inc;
    logic [KEY_CW-1:0]     kpos_inc;

    assign s_val       = r_s_vld ? r_s_rd : r_s_ra;
    assign j_nxt       = r_j + s_val + ((i_cmd.op == OP_KS_RDJ) ? r_k_rd : 8'd0);
    assign key_room    = (r_key_cnt < KEY_CW'(KEY_MAX));
    assign key_cnt_inc = key_room ? (r_key_cnt + KEY_CW'(1)) : r_key_cnt;
    assign kpos_inc    = KEY_CW'(r_kpos) + KEY_CW'(1);

    assign o_sts.ks_done  = (r_i == 8'hFF);
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_byte     = r_out_data;

    // S-box port control
    always_comb begin
        s_re = 1'b0;
        s_ra = r_i;
        s_we = 1'b0;
        s_wa = r_i;
        s_wd = r_tmp_a;
        unique case (i_cmd.op)
            OP_DATA_IN: begin
                s_re = 1'b1;
                s_ra = r_i + 8'd1;
            end
            OP_KS_RDN: begin
                s_re = 1'b1;
                s_ra = r_i;
            end
            OP_KS_RDJ, OP_D_RDJ: begin
                s_re = 1'b1;
                s_ra = j_nxt;
            end
            OP_KS_WRN, OP_D_WRI: begin
                s_we = 1'b1;
                s_wa = r_i;
                s_wd = s_val;
            end
            OP_KS_WRJ, OP_D_WRJ: begin
                s_we = 1'b1;
                s_wa = r_j;
                s_wd = r_tmp_a;
            end
            OP_D_RDK: begin
                s_re = 1'b1;
                s_ra = r_tmp_a + r_tmp_b;
            end
            default: begin
            end
        endcase
    end

    // S-box memory, registered read
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sbox[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_s_rd  <= r_sbox[s_ra];
            r_s_ra  <= s_ra;
            r_s_vld <= r_valid[s_ra];
        end
    end

    // Key memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_KEY_IN && key_room) begin
            r_key_mem[r_key_cnt[KEY_AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.op == OP_KS_RDN) begin
            r_k_rd <= r_key_mem[r_kpos];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_key_cnt <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_we) begin
                r_valid[s_wa] <= 1'b1;
            end
            unique case (i_cmd.op)
                OP_KEY_IN: begin
                    if (i_cmd.ks_start) begin
                        r_valid   <= '0;
                        r_key_cnt <= '0;
                        r_i       <= '0;
                        r_j       <= '0;
                    end else begin
                        r_key_cnt <= key_cnt_inc;
                    end
                end
                OP_DATA_IN: begin
                    r_i <= r_i + 8'd1;
                end
                OP_KS_RDJ, OP_D_RDJ: begin
                    r_j <= j_nxt;
                end
                OP_KS_WRJ: begin
                    // i doubles as the schedule counter and wraps to zero
                    r_i <= r_i + 8'd1;
                    if (o_sts.ks_done) begin
                        r_j <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == OP_D_OUT) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_KEY_IN: begin
                if (i_cmd.ks_start) begin
                    r_key_len <= key_cnt_inc;
                    r_kpos    <= '0;
                end
            end
            OP_DATA_IN: begin
                r_byte <= i_in_byte;
            end
            OP_KS_RDJ, OP_D_RDJ: begin
                r_tmp_a <= s_val;
            end
            OP_D_WRI: begin
                r_tmp_b <= s_val;
            end
            OP_KS_WRJ: begin
                // key repeats cyclically over the stored length
                r_kpos <= (kpos_inc >= r_key_len) ? '0 : kpos_inc[KEY_AW-1:0];
            end
            OP_D_OUT: begin
                r_out_data <= r_byte ^ s_val;
            end
            default: begin
            end
        endcase
    end

    // Schedule end leaves both indices at zero
    a_ks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_KS_WRJ && o_sts.ks_done) |=> (r_i == 8'd0 && r_j == 8'd0))
        else $error("indices not cleared after key schedule");

    // Single-port S-box: never read and write in one cycle
    a_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_we && s_re))
        else $error("S-box read and write in the same cycle");

    // Loading a result always presents it next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_D_OUT) |=> o_out_valid)
        else $error("loaded result not presented");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
    import rc4_pkg::*;

    // Meaning of s_axis_tuser
    typedef enum logic {
        MODE_KEY  = 1'b0,
        MODE_DATA = 1'b1
    } t_mode;

    localparam int KEY_LIMIT   = KEY_MAX_DEF;
    localparam int RAND_ITEMS  = 160;
    // Longest quiet time after the last result: one full key schedule plus a data request
    localparam int SETTLE_CYC  = 1100;
    localparam int LIMIT_CYC   = 1000000;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tuser  = 1'b0;    // [0] mode
    logic       s_axis_tlast  = 1'b0;    // key_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte

    // Idle control for both sides
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    int unsigned mismatches = 0;

    // Cipher state as the block should hold it
    logic [7:0]  perm [256];
    logic [7:0]  key_bytes [256];
    int unsigned key_len;
    logic [7:0]  pos_i;
    logic [7:0]  pos_j;
    logic [7:0]  out_bytes_due [$];
    logic [7:0]  due_byte;

    rc4_stream_cipher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic void cipher_clear();
        for (int n = 0; n < 256; n++) begin
            perm[n]      = 8'(n);
            key_bytes[n] = 8'h00;
        end
        key_len = 0;
        pos_i   = 8'h00;
        pos_j   = 8'h00;
    endfunction

    // Key scheduling: identity, then 256 swaps with the key repeated
    function automatic void schedule_key(int unsigned len);
        logic [7:0]  acc;
        logic [7:0]  tmp;
        int unsigned kpos;
        acc  = 8'h00;
        kpos = 0;
        for (int n = 0; n < 256; n++)
            perm[n] = 8'(n);
        for (int n = 0; n < 256; n++) begin
            acc       = acc + perm[n] + key_bytes[kpos[7:0]];
            tmp       = perm[n];
            perm[n]   = perm[acc];
            perm[acc] = tmp;
            kpos++;
            if (kpos >= len)
                kpos = 0;
        end
    endfunction

    // Advance the cipher by one accepted request; data requests queue a result
    function automatic void cipher_step(t_mode mode, logic [7:0] value, logic last);
        logic [7:0] tmp;
        logic [7:0] ks_idx;
        if (mode == MODE_KEY) begin
            if (key_len < KEY_LIMIT) begin
                key_bytes[key_len[7:0]] = value;
                key_len++;
            end
            if (last) begin
                schedule_key(key_len == 0 ? 1 : key_len);
                key_len = 0;
                pos_i   = 8'h00;
                pos_j   = 8'h00;
            end
        end else begin
            pos_i       = pos_i + 8'd1;
            pos_j       = pos_j + perm[pos_i];
            tmp         = perm[pos_i];
            perm[pos_i] = perm[pos_j];
            perm[pos_j] = tmp;
            ks_idx      = perm[pos_i] + perm[pos_j];
            out_bytes_due.push_back(value ^ perm[ks_idx]);
        end
    endfunction

    // ---------------- request side ----------------

    // Valid stays high after a handshake; within this task it drops only ahead of a gap
    task automatic send_item(t_mode mode, logic [7:0] value, logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_step(mode, value, last);
    endtask

    // Stop sending and hold off until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (out_bytes_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_key(int unsigned len);
        for (int k = 0; k < len; k++)
            send_item(MODE_KEY, 8'($urandom), k == len - 1);
    endtask

    // ---------------- result side ----------------

    initial begin : result_ready
        int unsigned stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (out_bytes_due.size() == 0) begin
                $error("out_byte: expected none, actual %02h", m_axis_tdata);
                mismatches++;
            end else begin
                due_byte = out_bytes_due.pop_front();
                if (m_axis_tdata !== due_byte) begin
                    $error("out_byte: expected %02h, actual %02h", due_byte, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // Keystream from the reset S-box; key_last on data is ignored
    task automatic test_data_before_key();
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b1);
        send_item(MODE_DATA, 8'h55, 1'b0);
        send_item(MODE_DATA, 8'hAA, 1'b1);
    endtask

    // One-byte keys at both byte extremes, then the classic three-byte key
    task automatic test_short_keys();
        logic [7:0] text [9];
        text = '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};
        send_item(MODE_KEY, 8'hFF, 1'b1);
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b0);
        send_item(MODE_KEY, 8'h00, 1'b1);
        send_item(MODE_DATA, 8'h3C, 1'b0);
        send_item(MODE_KEY, 8'h4B, 1'b0);
        send_item(MODE_KEY, 8'h65, 1'b0);
        send_item(MODE_KEY, 8'h79, 1'b1);
        foreach (text[n])
            send_item(MODE_DATA, text[n], 1'b0);
    endtask

    // Key past the maximum: the extra bytes are dropped
    task automatic test_long_key();
        send_key(KEY_LIMIT + 4);
        for (int n = 0; n < 4; n++)
            send_item(MODE_DATA, 8'($urandom), 1'b0);
    endtask

    // Mostly key-then-data sessions, some stray and broken requests
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned seg;
        int unsigned klen;
        int unsigned dlen;
        t_mode       mode;
        sent = 0;
        seg  = 0;
        while (sent < RAND_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (seg == 2)
                drain_results();
            if ($urandom_range(0, 3) != 0) begin
                klen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
                send_key(klen);
                dlen = $urandom_range(1, 24);
                for (int n = 0; n < dlen; n++)
                    send_item(MODE_DATA, 8'($urandom), 1'($urandom));
                sent += klen + dlen;
            end else begin
                dlen = $urandom_range(1, 3);
                for (int n = 0; n < dlen; n++) begin
                    mode = t_mode'($urandom_range(0, 1));
                    send_item(mode, 8'($urandom),
                              mode == MODE_DATA ? 1'($urandom)
                                                : ($urandom_range(0, 3) == 0));
                end
                sent += dlen;
            end
            seg++;
        end
    endtask

    // ---------------- sequence ----------------

    initial begin
        cipher_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_data_before_key();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_short_keys();
        tx_idle = 1'b0;
        test_long_key();
        tx_idle = 1'b1;
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(4 * LIMIT_CYC);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
